// ===== hdl/thumb_load_store_unit_defines.svh =====
// Assertion macros for the Thumb load/store unit.
`ifndef THUMB_LOAD_STORE_UNIT_DEFINES_SVH
`define THUMB_LOAD_STORE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TLSU_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define TLSU_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define TLSU_ASSERT_IMP(label, clk, rst, a, c)
`define TLSU_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/tlsu_pkg.sv =====
// Shared constants for the Thumb load/store unit.
package tlsu_pkg;
  localparam int MEM_BYTES_DEFAULT = 4096;
  localparam logic [2:0] CMD_EXEC = 3'd0;
  localparam logic [2:0] CMD_WREG = 3'd1;
  localparam logic [2:0] CMD_RREG = 3'd2;
  localparam logic [2:0] CMD_WMEM = 3'd3;
  localparam logic [2:0] CMD_RMEM = 3'd4;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;
endpackage

// ===== hdl/thumb_load_store_unit.sv =====
// Top level of the Thumb load/store unit: decoder, byte sequencer and register file.
// Sequencing: register commands finish after decode; memory accesses move one byte at a time,
// loads through a RAM read per byte, and STM/LDM step through the register list word by word.
// Throughput: one request at a time; busy is high until the result strobe.
// Reset: synchronous, clears r0-r7, SP and the sequencer; memory is not cleared.
// The result is shown for one cycle on done; the receiver cannot stall.
module thumb_load_store_unit #(
  parameter int MEM_BYTES = tlsu_pkg::MEM_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [15:0] instruction,
  input  logic [31:0] pc_value,
  input  logic [3:0]  reg_select,
  input  logic [11:0] mem_address,
  input  logic [31:0] write_value,
  output logic        done,
  output logic [31:0] read_value,
  output logic [1:0]  status
);
  `include "thumb_load_store_unit_defines.svh"

  localparam int AW = $clog2(MEM_BYTES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_MADR = 7'b0000100,
    S_MWT  = 7'b0001000,
    S_MRD  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic [2:0]  cmd;
  logic [15:0] ins;
  logic [31:0] pc;
  logic [3:0]  sel;
  logic [11:0] maddr;
  logic [31:0] wval;
  logic [31:0] regs [8];
  logic [31:0] sp;
  logic [31:0] addr;
  logic [31:0] data;
  logic [2:0]  len;
  logic [1:0]  bidx;
  logic        load;
  logic        sgn;
  logic [2:0]  rt;
  logic        multi;
  logic [7:0]  list;
  logic [2:0]  rn;
  logic [31:0] base;
  logic [3:0]  cnt;
  logic        lowest;
  logic        wb;
  logic [31:0] rv;
  logic [1:0]  st;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  tlsu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [2:0]  d_rt, d_rn, d_rm, d_hi8;
  logic [4:0]  d_imm5;
  logic [7:0]  d_imm8;
  logic [2:0]  d_op;
  logic [3:0]  d_count;
  logic [2:0]  d_first;
  logic [32:0] d_end;
  logic [31:0] cur_addr;
  logic [31:0] store_word;

  always_comb begin
    d_rt = ins[2:0];
    d_rn = ins[5:3];
    d_rm = ins[8:6];
    d_imm5 = ins[10:6];
    d_imm8 = ins[7:0];
    d_hi8 = ins[10:8];
    d_op = ins[11:9];
    d_count = '0;
    for (int j = 0; j < 8; j++) begin
      d_count = d_count + {3'd0, ins[j]};
    end
    d_first = '0;
    for (int j = 7; j >= 0; j--) begin
      if (list[j]) begin
        d_first = 3'(j);
      end
    end
    d_end = {1'b0, addr} + {30'd0, len};
    cur_addr = addr + {30'd0, bidx};
  end

  always_comb begin
    store_word = regs[d_first];
    if (multi && d_first == rn) begin
      store_word = lowest ? base : 32'd0;
    end
    if (!multi) begin
      store_word = regs[rt];
    end
  end

  assign busy = (state != S_IDLE);
  assign ram_we = (state == S_MWT) && !load;
  assign ram_addr = (cmd == tlsu_pkg::CMD_EXEC) ? cur_addr[AW-1:0] : AW'(maddr);
  assign ram_wdata = (cmd == tlsu_pkg::CMD_EXEC) ? data[8*bidx +: 8] : wval[7:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      for (int j = 0; j < 8; j++) begin
        regs[j] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= command; ins <= instruction; pc <= pc_value;
            sel <= reg_select; maddr <= mem_address; wval <= write_value;
            rv <= '0; st <= tlsu_pkg::ST_OK;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          bidx <= '0; data <= '0; multi <= 1'b0; sgn <= 1'b0; wb <= 1'b0;
          state <= S_MADR;
          case (cmd)
            tlsu_pkg::CMD_EXEC: begin
              load <= ins[11];
              if (ins[15:11] == 5'h09) begin
                addr <= {pc[31:2], 2'b00} + {22'd0, d_imm8, 2'b00};
                len <= 3'd4; load <= 1'b1; rt <= d_hi8;
              end else if (ins[15:12] == 4'h5) begin
                addr <= regs[d_rn] + regs[d_rm];
                rt <= d_rt;
                load <= d_op[2] || (d_op == 3'd3);
                sgn <= (d_op == 3'd3) || (d_op == 3'd7);
                case (d_op)
                  3'd0, 3'd4: len <= 3'd4;
                  3'd1, 3'd5, 3'd7: len <= 3'd2;
                  default: len <= 3'd1;
                endcase
              end else if (ins[15:13] == 3'h3) begin
                rt <= d_rt;
                len <= ins[12] ? 3'd1 : 3'd4;
                addr <= regs[d_rn] + (ins[12] ? {27'd0, d_imm5} : {25'd0, d_imm5, 2'b00});
              end else if (ins[15:12] == 4'h8) begin
                rt <= d_rt; len <= 3'd2;
                addr <= regs[d_rn] + {26'd0, d_imm5, 1'b0};
              end else if (ins[15:12] == 4'h9) begin
                rt <= d_hi8; len <= 3'd4;
                addr <= sp + {22'd0, d_imm8, 2'b00};
              end else if (ins[15:12] == 4'hC) begin
                multi <= 1'b1; list <= d_imm8; rn <= d_hi8; len <= 3'd4;
                base <= regs[d_hi8]; addr <= regs[d_hi8]; cnt <= d_count;
                lowest <= ((d_imm8 & ((8'd1 << d_hi8) - 8'd1)) == 8'd0);
                wb <= !(ins[11] && d_imm8[d_hi8]);
                if (d_count == 4'd0) begin
                  st <= tlsu_pkg::ST_EMPTY; state <= S_DONE;
                end
              end else begin
                st <= tlsu_pkg::ST_UNDEF; state <= S_DONE;
              end
            end
            tlsu_pkg::CMD_WREG: begin
              if (sel < 4'd8) regs[sel[2:0]] <= wval;
              else if (sel == 4'd8) sp <= wval;
              state <= S_DONE;
            end
            tlsu_pkg::CMD_RREG: begin
              if (sel < 4'd8) rv <= regs[sel[2:0]];
              else if (sel == 4'd8) rv <= sp;
              state <= S_DONE;
            end
            tlsu_pkg::CMD_WMEM, tlsu_pkg::CMD_RMEM: begin
              load <= (cmd == tlsu_pkg::CMD_RMEM);
              if ({20'd0, maddr} >= 32'(MEM_BYTES)) begin
                st <= tlsu_pkg::ST_RANGE; state <= S_DONE;
              end else begin
                state <= S_MWT;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_MADR: begin
          if (multi) begin
            if ({1'b0, base} + {27'd0, cnt, 2'b00} > 33'(MEM_BYTES)) begin
              st <= tlsu_pkg::ST_RANGE; state <= S_DONE;
            end else begin
              state <= S_NEXT;
            end
          end else if (d_end > 33'(MEM_BYTES)) begin
            st <= tlsu_pkg::ST_RANGE; state <= S_DONE;
          end else begin
            if (!load) data <= store_word;
            state <= S_MWT;
          end
        end
        S_NEXT: begin
          if (list == 8'd0) begin
            if (wb) regs[rn] <= base + {26'd0, cnt, 2'b00};
            state <= S_DONE;
          end else begin
            if (!load) data <= store_word;
            bidx <= '0;
            state <= S_MWT;
          end
        end
        S_MWT: begin
          state <= load ? S_MRD : S_MWT;
          if (!load) begin
            if (cmd != tlsu_pkg::CMD_EXEC || {1'b0, bidx} == len - 3'd1) begin
              state <= multi ? S_NEXT : S_DONE;
              if (multi) begin
                list[d_first] <= 1'b0; addr <= addr + 32'd4;
              end
            end else begin
              bidx <= bidx + 2'd1;
            end
          end
        end
        S_MRD: begin
          if (cmd != tlsu_pkg::CMD_EXEC) begin
            rv <= {24'd0, ram_rdata}; state <= S_DONE;
          end else begin
            data[8*bidx +: 8] <= ram_rdata;
            if ({1'b0, bidx} == len - 3'd1) begin
              if (multi) begin
                regs[d_first] <= {ram_rdata, data[23:0]};
                list[d_first] <= 1'b0; addr <= addr + 32'd4;
                state <= S_NEXT;
              end else begin
                case (len)
                  3'd1: regs[rt] <= {{24{sgn & ram_rdata[7]}}, ram_rdata};
                  3'd2: regs[rt] <= {{16{sgn & ram_rdata[7]}}, ram_rdata, data[7:0]};
                  default: regs[rt] <= {ram_rdata, data[23:0]};
                endcase
                state <= S_DONE;
              end
            end else begin
              bidx <= bidx + 2'd1; state <= S_MWT;
            end
          end
        end
        S_DONE: begin
          done <= 1'b1; read_value <= rv; status <= st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TLSU_ASSERT_NXT(a_done_one, clk, rst, done, !done)
  `TLSU_ASSERT_IMP(a_busy_done, clk, rst, done, !busy)
  `TLSU_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `TLSU_ASSERT_IMP(a_we_mem, clk, rst, ram_we, state == S_MWT)
endmodule

// ===== hdl/tlsu_ram.sv =====
// Generic single-port RAM with registered read.
module tlsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
